FILE: rtl/fdef_pkg.sv
package fdef_pkg;

  localparam int unsigned ChW   = 16;
  localparam int unsigned CoW   = 12;
  localparam int unsigned RoW   = 16;
  localparam int unsigned SqXW  = 38;
  localparam int unsigned SqQW  = 19;
  localparam int unsigned SqRW  = 21;
  localparam int unsigned SqItW = 5;
  localparam logic [SqItW-1:0] SqIters = 5'd19;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTENSITY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BORDER_WIDTH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_MODE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SIXTEEN_BIT  = 3'd5;

  localparam logic [2:0]     GainMax  = 3'd5;
  localparam logic [ChW-1:0] Mask8    = 16'h00FF;
  localparam logic [ChW-1:0] Mask16   = 16'hFFFF;

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
    logic [ChW-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0] red_out;
    logic [ChW-1:0] green_out;
    logic [ChW-1:0] blue_out;
    logic [ChW-1:0] alpha_out;
    logic [CoW-1:0] column;
    logic [RoW-1:0] row;
    logic           run_last;
    logic           frame_last;
  } pix_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLAN, ST_PICK, ST_RD_C, ST_RD_R, ST_RD_B,
    ST_SQUARE, ST_SUM, ST_ROOT, ST_FIN, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_CENTER, RD_RIGHT, RD_BELOW
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    plan;
    logic    pick;
    rd_sel_e rd_sel;
    logic    hold_c;
    logic    hold_r;
    logic    square;
    logic    sum;
    logic    root;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic any_left;
    logic root_done;
  } dp_sts_t;

endpackage

FILE: rtl/fdef_ctrl.sv
module fdef_ctrl
  import fdef_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_CENTER;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_PICK;
      end
      ST_PICK: begin
        if (sts_i.any_left) begin
          cmd_o.pick = 1'b1;
          state_d    = ST_RD_C;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_C: begin
        cmd_o.rd_sel = RD_CENTER;
        state_d      = ST_RD_R;
      end
      ST_RD_R: begin
        cmd_o.rd_sel = RD_RIGHT;
        cmd_o.hold_c = 1'b1;
        state_d      = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_sel = RD_BELOW;
        cmd_o.hold_r = 1'b1;
        state_d      = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        if (sts_i.root_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_PICK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/fdef_dp.sv
module fdef_dp
  import fdef_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_BORDER = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  pix_in_t             in_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output pix_out_t            out_data_o
);

  localparam int unsigned Slots = MAX_BORDER + 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned MCW   = $clog2(MAX_WIDTH);
  localparam int unsigned AW    = $clog2(MAX_WIDTH * Slots);
  localparam int unsigned SW    = $clog2(Slots);
  localparam int unsigned BW    = $clog2(MAX_BORDER + 1);
  localparam int unsigned NW    = $clog2(MAX_BORDER + 2);
  localparam int unsigned XW    = (CW > 13) ? CW : 13;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s == SW'(Slots - 1)) ? '0 : s + SW'(1);
    return r;
  endfunction

  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s,
                                               input logic [BW-1:0] off);
    logic [SW:0] t;
    t = {1'b0, s} + (SW+1)'(Slots) - (SW+1)'(off);
    if (t >= (SW+1)'(Slots)) begin
      t = t - (SW+1)'(Slots);
    end
    return t[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [SW-1:0] s,
                                             input logic [CW-1:0] c);
    logic [AW-1:0] a;
    a = AW'(s) * AW'(MAX_WIDTH) + AW'(c[MCW-1:0]);
    return a;
  endfunction

  logic [12:0] cfg_w_q;
  logic [15:0] cfg_h_q;
  logic [2:0]  cfg_gain_q;
  logic [2:0]  cfg_bw_q;
  logic        cfg_mode_q;
  logic        cfg_wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 13'd1;
      cfg_h_q    <= 16'd1;
      cfg_gain_q <= 3'd3;
      cfg_bw_q   <= 3'd2;
      cfg_mode_q <= 1'b0;
      cfg_wide_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_w_q    <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT: cfg_h_q    <= cfg_data_i;
        CFG_INTENSITY:    cfg_gain_q <= cfg_data_i[2:0];
        CFG_BORDER_WIDTH: cfg_bw_q   <= cfg_data_i[2:0];
        CFG_EDGE_MODE:    cfg_mode_q <= cfg_data_i[0];
        CFG_SIXTEEN_BIT:  cfg_wide_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0]  w_x;
  logic [CW-1:0]  w_e, w_m1;
  logic [15:0]    h_e, h_m1;
  logic [3:0]     bw_x;
  logic [BW-1:0]  bw_e;
  logic [2:0]     gain_e;
  logic [ChW-1:0] cmask;

  always_comb begin
    w_x = XW'(cfg_w_q);
    if (w_x == '0) begin
      w_e = CW'(1);
    end else if (w_x > XW'(MAX_WIDTH)) begin
      w_e = CW'(MAX_WIDTH);
    end else begin
      w_e = CW'(w_x);
    end
    w_m1 = w_e - CW'(1);
    h_e  = (cfg_h_q == '0) ? 16'd1 : cfg_h_q;
    h_m1 = h_e - 16'd1;
    bw_x = {1'b0, cfg_bw_q};
    if (bw_x == '0) begin
      bw_e = BW'(1);
    end else if (bw_x > 4'(MAX_BORDER)) begin
      bw_e = BW'(MAX_BORDER);
    end else begin
      bw_e = BW'(bw_x);
    end
    gain_e = (cfg_gain_q > GainMax) ? GainMax : cfg_gain_q;
    cmask  = cfg_wide_q ? Mask16 : Mask8;
  end

  logic [CW-1:0] col_cnt_q;
  logic [15:0]   row_cnt_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] c0, c1, c1x;
  logic [16:0]   r0x, r1x;
  logic [15:0]   r0, r1;
  logic [SW-1:0] s0, s1;
  logic          col_wrap, c1_wrap;

  always_comb begin
    col_wrap = col_cnt_q >= w_e;
    c0  = col_wrap ? '0 : col_cnt_q;
    r0x = {1'b0, row_cnt_q} + {16'd0, col_wrap};
    r0  = (r0x >= {1'b0, h_e}) ? '0 : r0x[15:0];
    s0  = (r0 == '0) ? '0 : (col_wrap ? slot_inc(slot_q) : slot_q);
    c1x = c0 + CW'(1);
    c1_wrap = c1x >= w_e;
    c1  = c1_wrap ? '0 : c1x;
    r1x = {1'b0, r0} + {16'd0, c1_wrap};
    r1  = (r1x >= {1'b0, h_e}) ? '0 : r1x[15:0];
    s1  = (r1 == '0) ? '0 : (c1_wrap ? slot_inc(s0) : s0);
  end

  logic [CW-1:0] cc_q;
  logic [15:0]   rr_q;
  logic [SW-1:0] wslot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      slot_q    <= '0;
    end else if (cmd_i.accept) begin
      col_cnt_q <= c1;
      row_cnt_q <= r1;
      slot_q    <= s1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cc_q    <= c0;
      rr_q    <= r0;
      wslot_q <= s0;
    end
  end

  logic [NW-1:0] a_cnt_q, b_cnt_q;
  logic [15:0]   a_row_q;
  logic [BW-1:0] a_k_q;
  logic [CW-1:0] b_col_q;
  logic [BW-1:0] min_bh, min_bw;
  logic [NW:0]   left_sum;

  always_comb begin
    min_bh   = (h_m1 < 16'(bw_e)) ? h_m1[BW-1:0] : bw_e;
    min_bw   = (w_m1 < CW'(bw_e)) ? w_m1[BW-1:0] : bw_e;
    left_sum = (NW+1)'(a_cnt_q) + (NW+1)'(b_cnt_q);
  end

  assign sts_o.any_left = (a_cnt_q != '0) || (b_cnt_q != '0);

  logic [CW-1:0] em_col_q;
  logic [15:0]   em_row_q;
  logic [BW-1:0] em_k_q;
  logic          em_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
    end else if (cmd_i.plan) begin
      if (rr_q != h_m1) begin
        a_cnt_q <= (rr_q >= 16'(bw_e)) ? NW'(1) : '0;
        b_cnt_q <= '0;
      end else begin
        a_cnt_q <= NW'(min_bh);
        if (cc_q < w_m1) begin
          b_cnt_q <= (cc_q >= CW'(bw_e)) ? NW'(1) : '0;
        end else begin
          b_cnt_q <= NW'(min_bw) + NW'(1);
        end
      end
    end else if (cmd_i.pick) begin
      if (a_cnt_q != '0) begin
        a_cnt_q <= a_cnt_q - NW'(1);
      end else begin
        b_cnt_q <= b_cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      if (rr_q != h_m1) begin
        a_row_q <= rr_q - 16'(bw_e);
        a_k_q   <= bw_e;
      end else begin
        a_row_q <= h_m1 - 16'(min_bh);
        a_k_q   <= min_bh;
      end
      if (cc_q < w_m1) begin
        b_col_q <= cc_q - CW'(bw_e);
      end else begin
        b_col_q <= w_m1 - CW'(min_bw);
      end
    end else if (cmd_i.pick) begin
      em_last_q <= (left_sum == (NW+1)'(1));
      if (a_cnt_q != '0) begin
        em_col_q <= cc_q;
        em_row_q <= a_row_q;
        em_k_q   <= a_k_q;
        a_row_q  <= a_row_q + 16'd1;
        a_k_q    <= a_k_q - BW'(1);
      end else begin
        em_col_q <= b_col_q;
        em_row_q <= rr_q;
        em_k_q   <= '0;
        b_col_q  <= b_col_q + CW'(1);
      end
    end
  end

  logic [CW-1:0] rem_w;
  logic [15:0]   rem_h;
  logic [BW-1:0] dx, dy;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;

  always_comb begin
    rem_w = w_m1 - em_col_q;
    rem_h = h_m1 - em_row_q;
    dx = (rem_w < CW'(bw_e)) ? rem_w[BW-1:0] : bw_e;
    dy = (rem_h < 16'(bw_e)) ? rem_h[BW-1:0] : bw_e;
    case (cmd_i.rd_sel)
      RD_RIGHT: rd_addr = mk_addr(slot_back(wslot_q, em_k_q), em_col_q + CW'(dx));
      RD_BELOW: rd_addr = mk_addr(slot_back(wslot_q, em_k_q - dy), em_col_q);
      default:  rd_addr = mk_addr(slot_back(wslot_q, em_k_q), em_col_q);
    endcase
    wr_addr = mk_addr(s0, c0);
    wr_data = {in_data_i.alpha_in & cmask, in_data_i.blue_in & cmask,
               in_data_i.green_in & cmask, in_data_i.red_in & cmask};
  end

  logic [63:0] line_store_q [Slots*MAX_WIDTH];
  logic [63:0] rd_data_q, c_q, r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      line_store_q[wr_addr] <= wr_data;
    end
    rd_data_q <= line_store_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_c) begin
      c_q <= rd_data_q;
    end
    if (cmd_i.hold_r) begin
      r_q <= rd_data_q;
    end
  end

  logic [2:0][ChW-1:0]    d1, d2;
  logic [2:0][31:0]       sq1_q, sq2_q;
  logic [2:0][SqXW-1:0]   x_q;
  logic [2:0][SqRW-1:0]   rem_q;
  logic [2:0][SqQW-1:0]   res_q;
  logic [SqItW-1:0]       it_q;
  logic [2:0][SqRW+1:0]   rem_n;
  logic [2:0][SqRW+1:0]   trial;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [ChW-1:0] p, q, s;
      p = c_q[16*k +: 16] & cmask;
      q = r_q[16*k +: 16] & cmask;
      s = rd_data_q[16*k +: 16] & cmask;
      d1[k] = (p > q) ? p - q : q - p;
      d2[k] = (p > s) ? p - s : s - p;
      rem_n[k] = {rem_q[k], x_q[k][SqXW-1 -: 2]};
      trial[k] = (SqRW+2)'({res_q[k], 2'b01});
    end
  end

  assign sts_o.root_done = (it_q == SqItW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      for (int k = 0; k < 3; k++) begin
        sq1_q[k] <= d1[k] * d1[k];
        sq2_q[k] <= d2[k] * d2[k];
      end
    end
    if (cmd_i.sum) begin
      for (int k = 0; k < 3; k++) begin
        x_q[k]   <= SqXW'({1'b0, sq1_q[k]} + {1'b0, sq2_q[k]}) << gain_e;
        rem_q[k] <= '0;
        res_q[k] <= '0;
      end
      it_q <= SqIters;
    end else if (cmd_i.root) begin
      for (int k = 0; k < 3; k++) begin
        x_q[k] <= x_q[k] << 2;
        if (rem_n[k] >= trial[k]) begin
          rem_q[k] <= SqRW'(rem_n[k] - trial[k]);
          res_q[k] <= {res_q[k][SqQW-2:0], 1'b1};
        end else begin
          rem_q[k] <= SqRW'(rem_n[k]);
          res_q[k] <= {res_q[k][SqQW-2:0], 1'b0};
        end
      end
      it_q <= it_q - SqItW'(1);
    end
  end

  logic [2:0][ChW-1:0] mag;
  pix_out_t            out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = (res_q[k] > SqQW'(cmask)) ? cmask : res_q[k][ChW-1:0];
      if (cfg_mode_q) begin
        mag[k] = cmask - mag[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.red_out    <= mag[0];
      out_q.green_out  <= mag[1];
      out_q.blue_out   <= mag[2];
      out_q.alpha_out  <= c_q[63:48] & cmask;
      out_q.column     <= CoW'(em_col_q);
      out_q.row        <= em_row_q;
      out_q.run_last   <= em_last_q;
      out_q.frame_last <= (em_col_q == w_m1) && (em_row_q == h_m1);
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/forward_difference_edge_filter.sv
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i / in_stall_o    in_data_i  (pix_in_t)
// out      out  out_valid_o / out_stall_i  out_data_o (pix_out_t)
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item releases 0 to 2*MAX_BORDER+1 results and is done once the last is taken,
// output stalls included; each result waits on the 19-step square-root unit and on
// the single line-store read port, which reads centre, right and below in turn.
// Reset clears configuration to defaults and the pixel counters; the line store is
// not cleared. Input is stalled from acceptance until the item's last result is taken.
module forward_difference_edge_filter
  import fdef_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_BORDER = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fdef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fdef_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_BORDER (MAX_BORDER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/fdef_chk.sv
module fdef_chk
  import fdef_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item changed");

  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("item not followed by gap");

  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while item pending");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_last |-> out_data_o.run_last)
    else $error("frame end not last of run");

endmodule

bind forward_difference_edge_filter fdef_chk u_chk (.*);

FILE: dv/forward_difference_edge_filter_tb.sv
`timescale 1ns / 100ps

module forward_difference_edge_filter_tb;
  import fdef_pkg::*;

  localparam int unsigned WMAX = 4096;
  localparam int unsigned BMAX = 5;
  localparam int unsigned SETTLE = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pix_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  forward_difference_edge_filter #(.MAX_WIDTH(WMAX), .MAX_BORDER(BMAX)) DUT (.*);

  always #5 clk_i = ~clk_i;

  int unsigned img_w, img_h, gain_cfg, border_cfg, edge_cfg, wide_cfg;
  int unsigned col_pos, row_pos;
  logic [63:0] line_mem [int];

  pix_in_t  pending_pix [$];
  pix_out_t expected_pix [$];
  int errors, pix_sent, pix_checked, phases;
  bit calm, held;
  int hold_cnt;

  task automatic report(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp, pix_checked);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int cell_idx(int unsigned c, int unsigned r);
    return (r % (BMAX + 1)) * WMAX + (c % WMAX);
  endfunction

  function automatic logic [63:0] cell_rd(int unsigned c, int unsigned r);
    int k;
    k = cell_idx(c, r);
    return line_mem.exists(k) ? line_mem[k] : 64'd0;
  endfunction

  function automatic void emit_edge(int unsigned c, int unsigned r, int unsigned w,
                                    int unsigned h, int unsigned bw, int unsigned g);
    int unsigned dx, dy;
    logic [63:0] ctr, rgt, blw;
    longint unsigned cm, p, q, s, d1, d2, m;
    logic [ChW-1:0] ch [3];
    pix_out_t o;
    dx = (w - 1 - c < bw) ? w - 1 - c : bw;
    dy = (h - 1 - r < bw) ? h - 1 - r : bw;
    ctr = cell_rd(c, r);
    rgt = cell_rd(c + dx, r);
    blw = cell_rd(c, r + dy);
    cm = wide_cfg ? 64'hFFFF : 64'hFF;
    for (int k = 0; k < 3; k++) begin
      p = (ctr >> (16 * k)) & cm;
      q = (rgt >> (16 * k)) & cm;
      s = (blw >> (16 * k)) & cm;
      d1 = p > q ? p - q : q - p;
      d2 = p > s ? p - s : s - p;
      m = int_sqrt((d1 * d1 + d2 * d2) << g);
      if (m > cm) m = cm;
      ch[k] = ChW'(edge_cfg ? cm - m : m);
    end
    o.red_out = ch[0];
    o.green_out = ch[1];
    o.blue_out = ch[2];
    o.alpha_out = ChW'((ctr >> 48) & cm);
    o.column = c[CoW-1:0];
    o.row = r[RoW-1:0];
    o.run_last = 1'b0;
    o.frame_last = (c == w - 1 && r == h - 1);
    expected_pix.push_back(o);
  endfunction

  function automatic void filter_pixel(pix_in_t px);
    int unsigned w, h, bw, g, cc, rr, lo, n0;
    logic [63:0] cm;
    w = img_w == 0 ? 1 : (img_w > WMAX ? WMAX : img_w);
    h = img_h == 0 ? 1 : img_h;
    bw = border_cfg < 1 ? 1 : (border_cfg > BMAX ? BMAX : border_cfg);
    g = gain_cfg > 5 ? 5 : gain_cfg;
    cm = wide_cfg ? 64'hFFFF : 64'hFF;
    n0 = expected_pix.size();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    cc = col_pos;
    rr = row_pos;
    line_mem[cell_idx(cc, rr)] = (px.red_in & cm) | ((px.green_in & cm) << 16) |
                                 ((px.blue_in & cm) << 32) | ((px.alpha_in & cm) << 48);
    if (rr < h - 1) begin
      if (rr >= bw) emit_edge(cc, rr - bw, w, h, bw, g);
    end else begin
      lo = (h - 1 > bw) ? h - 1 - bw : 0;
      for (int unsigned i = lo; i < h - 1; i++) emit_edge(cc, i, w, h, bw, g);
      if (cc < w - 1) begin
        if (cc >= bw) emit_edge(cc - bw, h - 1, w, h, bw, g);
      end else begin
        lo = (w - 1 > bw) ? w - 1 - bw : 0;
        for (int unsigned i = lo; i < w; i++) emit_edge(i, h - 1, w, h, bw, g);
      end
    end
    if (expected_pix.size() > n0) expected_pix[expected_pix.size() - 1].run_last = 1'b1;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        filter_pixel(in_data_i);
        pix_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pix.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
          in_data_i <= pending_pix.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pix.size() == 0) begin
          report("unexpected result", 64'(out_data_o), 0);
        end else begin
          pix_out_t e;
          e = expected_pix.pop_front();
          if (out_data_o.red_out != e.red_out) report("red_out", out_data_o.red_out, e.red_out);
          if (out_data_o.green_out != e.green_out)
            report("green_out", out_data_o.green_out, e.green_out);
          if (out_data_o.blue_out != e.blue_out)
            report("blue_out", out_data_o.blue_out, e.blue_out);
          if (out_data_o.alpha_out != e.alpha_out)
            report("alpha_out", out_data_o.alpha_out, e.alpha_out);
          if (out_data_o.column != e.column) report("column", out_data_o.column, e.column);
          if (out_data_o.row != e.row) report("row", out_data_o.row, e.row);
          if (out_data_o.run_last != e.run_last)
            report("run_last", out_data_o.run_last, e.run_last);
          if (out_data_o.frame_last != e.frame_last)
            report("frame_last", out_data_o.frame_last, e.frame_last);
        end
        pix_checked++;
      end
      if (!held && pix_checked == 30) begin
        held = 1'b1;
        hold_cnt <= 500;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 27);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val & 16'h1FFF;
      CFG_IMAGE_HEIGHT: img_h = val;
      CFG_INTENSITY:    gain_cfg = val & 7;
      CFG_BORDER_WIDTH: border_cfg = val & 7;
      CFG_EDGE_MODE:    edge_cfg = val & 1;
      CFG_SIXTEEN_BIT:  wide_cfg = val & 1;
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned g, int unsigned bw,
                       int unsigned md, int unsigned s16);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_INTENSITY, g);
    write_reg(CFG_BORDER_WIDTH, bw);
    write_reg(CFG_EDGE_MODE, md);
    write_reg(CFG_SIXTEEN_BIT, s16);
    phases++;
  endtask

  task automatic drain();
    while (pending_pix.size() > 0 || in_valid_i || expected_pix.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic pix_in_t rand_pix();
    pix_in_t p;
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      default: p = {$urandom, $urandom};
    endcase
    return p;
  endfunction

  initial begin
    int unsigned w, h, n, rand_items;
    img_w = 1; img_h = 1; gain_cfg = 3; border_cfg = 2; edge_cfg = 0; wide_cfg = 0;
    col_pos = 0; row_pos = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    pending_pix.push_back('0);
    pending_pix.push_back('1);
    pending_pix.push_back({16'h00FF, 16'hFF00, 16'h1234, 16'hABCD});
    drain();

    setup(5, 4, 5, 1, 0, 1);
    for (int i = 0; i < 20; i++)
      pending_pix.push_back(((i + i / 5) % 2) ? pix_in_t'('1) : pix_in_t'('0));
    drain();

    setup(4096, 1, 0, 5, 1, 0);
    calm = 1'b1;
    for (int i = 0; i < 64; i++) pending_pix.push_back(rand_pix());
    drain();
    calm = 1'b0;

    setup(3, 0, 4, 0, 1, 1);
    for (int i = 0; i < 6; i++) pending_pix.push_back(rand_pix());
    drain();

    setup(1, 65535, 7, 7, 0, 1);
    for (int i = 0; i < 20; i++) pending_pix.push_back(rand_pix());
    drain();

    rand_items = 0;
    while (rand_items < 240) begin
      w = $urandom_range(12);
      h = $urandom_range(8);
      setup(w, h, $urandom_range(7), $urandom_range(7), $urandom_range(1),
            $urandom_range(1));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      n = w * h * $urandom_range(1, 2);
      for (int i = 0; i < n; i++) pending_pix.push_back(rand_pix());
      rand_items += n;
      drain();
    end

    $display("covered %0d configurations, %0d pixels in, %0d results checked",
             phases, pix_sent, pix_checked);
    $display("widths 1 to 4096, heights 0 to 65535, all gains, borders and modes");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", expected_pix.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fdef_pkg.sv
rtl/fdef_ctrl.sv
rtl/fdef_dp.sv
rtl/forward_difference_edge_filter.sv
rtl/fdef_chk.sv
dv/forward_difference_edge_filter_tb.sv
